// File: rtl/ppp_pkg.sv
// ----------------------------------------------------------------------------
// Perspective point plotter package
// Screen geometry, field widths, command codes, register indexes and the
// request and response structs of the per-axis projection unit.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int SCREEN_COLUMNS = 64;
  localparam int SCREEN_ROWS    = 32;

  localparam int COL_W      = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W      = $clog2(SCREEN_ROWS);
  localparam int ROW_BITS_W = 64;

  localparam int COORD_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DEN_W     = COORD_W + 2;
  localparam int DIV_W     = DEN_W - 1;
  localparam int QUO_W     = 2 * CFG_W;

  localparam int MUL_STEPS = COORD_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = $clog2(2 * MUL_STEPS);

  localparam logic [COL_W:0]   COL_MID   = (COL_W + 1)'(SCREEN_COLUMNS / 2);
  localparam logic [ROW_W:0]   ROW_MID   = (ROW_W + 1)'(SCREEN_ROWS / 2);
  localparam logic [QUO_W-1:0] COL_MID_Q = QUO_W'(SCREEN_COLUMNS / 2);
  localparam logic [QUO_W-1:0] ROW_MID_Q = QUO_W'(SCREEN_ROWS / 2);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PLOT  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_FOV     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_H = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_V = CFG_IDX_W'(2);

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] mag;
    logic [CFG_W-1:0]   fov;
    logic [CFG_W-1:0]   scale;
    logic [DIV_W-1:0]   divisor;
  } axis_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } axis_rsp_t;

endpackage

// File: rtl/perspective_point_plotter.sv
// A plot is taken, then both axis units multiply and then divide, side by side; an
// on-screen plot then passes the fetch and modify states, an off-screen one goes
// straight to emit, as do a clear, an unknown command and a zero-denominator plot.
// A row read passes the read state first, for the registered bitmap memory port.
// The next transaction can be taken in the cycle the result appears; a stalled result holds emit.
// Reset sets the registers to 256 and clears every row valid bit, so the frame is 0.
// ----------------------------------------------------------------------------
// Perspective point plotter
// Keeps a one-bit-per-pixel frame, projects Q8.8 points onto it, and clears
// or reads back bitmap rows on command.
// ----------------------------------------------------------------------------
module perspective_point_plotter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_command,
  input  logic signed [ppp_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [ppp_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [ppp_pkg::COORD_W-1:0] in_coord_z,
  input  logic [4:0]                        in_row_select,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_on_screen,
  output logic [5:0]                        out_pixel_column,
  output logic [4:0]                        out_pixel_row,
  output logic [63:0]                       out_row_bits,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppp_pkg::CFG_W-1:0]         cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PROJ   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_FETCH  = 6'b001000,
    ST_MODIFY = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t                             state_r, state_nxt;
  logic [ppp_pkg::CFG_W-1:0]          fov_r, scale_h_r, scale_v_r;
  logic [ppp_pkg::SCREEN_ROWS-1:0]    row_valid_r, row_valid_nxt;
  logic                               out_valid_r, out_valid_nxt;

  logic                               res_on_r, res_on_nxt;
  logic [ppp_pkg::COL_W-1:0]          res_col_r, res_col_nxt;
  logic [ppp_pkg::ROW_W-1:0]          res_row_r, res_row_nxt;
  logic [ppp_pkg::ROW_BITS_W-1:0]     res_bits_r, res_bits_nxt;
  logic                               neg_x_r, neg_x_nxt;
  logic                               neg_y_r, neg_y_nxt;
  logic [ppp_pkg::ROW_W-1:0]          rd_row_r, rd_row_nxt;
  logic                               rd_ok_r, rd_ok_nxt;

  logic                               out_on_r;
  logic [ppp_pkg::COL_W-1:0]          out_col_r;
  logic [ppp_pkg::ROW_W-1:0]          out_row_r;
  logic [ppp_pkg::ROW_BITS_W-1:0]     out_bits_r;
  logic                               out_load;

  logic [ppp_pkg::ROW_BITS_W-1:0]     bitmap_mem [ppp_pkg::SCREEN_ROWS];
  logic [ppp_pkg::ROW_BITS_W-1:0]     mem_rdata_r;
  logic                               mem_re, mem_we;
  logic [ppp_pkg::ROW_W-1:0]          mem_raddr;
  logic [ppp_pkg::ROW_BITS_W-1:0]     mem_wdata;

  logic                               in_take;
  logic [ppp_pkg::DEN_W-1:0]          den, den_neg;
  logic [ppp_pkg::DIV_W-1:0]          den_mag;
  logic [ppp_pkg::COORD_W-1:0]        neg_cx, neg_cy, mag_x, mag_y;
  logic                               plot_go;
  logic                               on_x, on_y;
  logic [ppp_pkg::COL_W:0]            col_calc;
  logic [ppp_pkg::ROW_W:0]            row_calc;

  ppp_pkg::axis_req_t                 req_x, req_y;
  ppp_pkg::axis_rsp_t                 rsp_x, rsp_y;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fov_r     <= ppp_pkg::CFG_RESET;
      scale_h_r <= ppp_pkg::CFG_RESET;
      scale_v_r <= ppp_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppp_pkg::REG_FOV:     fov_r     <= cfg_data;
        ppp_pkg::REG_SCALE_H: scale_h_r <= cfg_data;
        ppp_pkg::REG_SCALE_V: scale_v_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    den     = {{2{in_coord_z[ppp_pkg::COORD_W-1]}}, in_coord_z} + {2'b00, fov_r};
    den_neg = -den;
    den_mag = den[ppp_pkg::DEN_W-1] ? den_neg[ppp_pkg::DIV_W-1:0]
                                    : den[ppp_pkg::DIV_W-1:0];
    neg_cx  = -in_coord_x;
    neg_cy  = -in_coord_y;
    mag_x   = in_coord_x[ppp_pkg::COORD_W-1] ? neg_cx : in_coord_x;
    mag_y   = in_coord_y[ppp_pkg::COORD_W-1] ? neg_cy : in_coord_y;
    plot_go = in_take && (in_command == ppp_pkg::CMD_PLOT) && (den != '0);

    req_x.start   = plot_go;
    req_x.mag     = mag_x;
    req_x.fov     = fov_r;
    req_x.scale   = scale_h_r;
    req_x.divisor = den_mag;
    req_y.start   = plot_go;
    req_y.mag     = mag_y;
    req_y.fov     = fov_r;
    req_y.scale   = scale_v_r;
    req_y.divisor = den_mag;
  end

  ppp_axis u_axis_x (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_x),
    .rsp   (rsp_x)
  );

  ppp_axis u_axis_y (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_y),
    .rsp   (rsp_y)
  );

  always_comb begin
    on_x = neg_x_r ? (rsp_x.quotient <= ppp_pkg::COL_MID_Q)
                   : (rsp_x.quotient <  ppp_pkg::COL_MID_Q);
    on_y = neg_y_r ? (rsp_y.quotient <= ppp_pkg::ROW_MID_Q)
                   : (rsp_y.quotient <  ppp_pkg::ROW_MID_Q);
    col_calc = neg_x_r
      ? ppp_pkg::COL_MID - {1'b0, rsp_x.quotient[ppp_pkg::COL_W-1:0]}
      : ppp_pkg::COL_MID + {1'b0, rsp_x.quotient[ppp_pkg::COL_W-1:0]};
    row_calc = neg_y_r
      ? ppp_pkg::ROW_MID - {1'b0, rsp_y.quotient[ppp_pkg::ROW_W-1:0]}
      : ppp_pkg::ROW_MID + {1'b0, rsp_y.quotient[ppp_pkg::ROW_W-1:0]};
  end

  always_comb begin
    state_nxt     = state_r;
    row_valid_nxt = row_valid_r;
    res_on_nxt    = res_on_r;
    res_col_nxt   = res_col_r;
    res_row_nxt   = res_row_r;
    res_bits_nxt  = res_bits_r;
    neg_x_nxt     = neg_x_r;
    neg_y_nxt     = neg_y_r;
    rd_row_nxt    = rd_row_r;
    rd_ok_nxt     = rd_ok_r;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_raddr     = res_row_r;
    mem_wdata     = (row_valid_r[res_row_r] ? mem_rdata_r : '0)
                  | (ppp_pkg::ROW_BITS_W'(1) << res_col_r);
    out_load      = 1'b0;
    out_valid_nxt = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          res_on_nxt   = 1'b0;
          res_col_nxt  = '0;
          res_row_nxt  = '0;
          res_bits_nxt = '0;
          state_nxt    = ST_EMIT;
          case (in_command)
            ppp_pkg::CMD_CLEAR: begin
              row_valid_nxt = '0;
            end
            ppp_pkg::CMD_PLOT: begin
              neg_x_nxt = in_coord_x[ppp_pkg::COORD_W-1] ^ den[ppp_pkg::DEN_W-1];
              neg_y_nxt = in_coord_y[ppp_pkg::COORD_W-1] ^ den[ppp_pkg::DEN_W-1];
              if (den != '0) begin
                state_nxt = ST_PROJ;
              end
            end
            ppp_pkg::CMD_READ: begin
              rd_row_nxt = in_row_select[ppp_pkg::ROW_W-1:0];
              rd_ok_nxt  = (32'(in_row_select) < ppp_pkg::SCREEN_ROWS);
              mem_re     = 1'b1;
              mem_raddr  = in_row_select[ppp_pkg::ROW_W-1:0];
              state_nxt  = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PROJ: begin
        if (rsp_x.done) begin
          if (on_x && on_y) begin
            res_on_nxt  = 1'b1;
            res_col_nxt = col_calc[ppp_pkg::COL_W-1:0];
            res_row_nxt = row_calc[ppp_pkg::ROW_W-1:0];
            state_nxt   = ST_FETCH;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_READ: begin
        res_bits_nxt = (rd_ok_r && row_valid_r[rd_row_r]) ? mem_rdata_r : '0;
        state_nxt    = ST_EMIT;
      end
      ST_FETCH: begin
        mem_re    = 1'b1;
        state_nxt = ST_MODIFY;
      end
      ST_MODIFY: begin
        mem_we                   = 1'b1;
        row_valid_nxt[res_row_r] = 1'b1;
        state_nxt                = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[res_row_r] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= bitmap_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_valid_r <= row_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_on_r   <= res_on_nxt;
    res_col_r  <= res_col_nxt;
    res_row_r  <= res_row_nxt;
    res_bits_r <= res_bits_nxt;
    neg_x_r    <= neg_x_nxt;
    neg_y_r    <= neg_y_nxt;
    rd_row_r   <= rd_row_nxt;
    rd_ok_r    <= rd_ok_nxt;
    if (out_load) begin
      out_on_r   <= res_on_r;
      out_col_r  <= res_col_r;
      out_row_r  <= res_row_r;
      out_bits_r <= res_bits_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_on_screen    = out_on_r;
  assign out_pixel_column = out_col_r;
  assign out_pixel_row    = out_row_r;
  assign out_row_bits     = out_bits_r;

`ifndef SYNTHESIS
  a_axes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_x.done == rsp_y.done)
    else $error("Axis units finished in different cycles.");

  a_done_in_proj: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_x.done |-> state_r == ST_PROJ)
    else $error("Projection finished outside the projection state.");

  a_plot_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_on_screen |-> out_row_bits == '0)
    else $error("Plot transaction carries row bits.");

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != ST_IDLE)
    else $error("Accepted transaction left the controller idle.");
`endif

endmodule

// File: rtl/ppp_axis.sv
// ----------------------------------------------------------------------------
// Perspective point plotter axis unit
// Forms |c| * fov * scale with a radix-2 shift-add multiplier, drops the
// sixteen fraction bits, then divides by |z + fov| with a bit-serial
// restoring divider that shifts one dividend bit in per cycle.
// ----------------------------------------------------------------------------
module ppp_axis (
  input  logic                clk,
  input  logic                rst_n,
  input  ppp_pkg::axis_req_t  req,
  output ppp_pkg::axis_rsp_t  rsp
);

  typedef enum logic [2:0] {
    AX_IDLE = 3'b001,
    AX_MUL  = 3'b010,
    AX_DIV  = 3'b100
  } ax_state_t;

  ax_state_t                      state_r, state_nxt;
  logic [ppp_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                           done_r, done_nxt;
  logic [ppp_pkg::QUO_W-1:0]      hi_r, hi_nxt;
  logic [ppp_pkg::COORD_W-1:0]    lo_r, lo_nxt;
  logic [ppp_pkg::QUO_W-1:0]      mcand_r, mcand_nxt;
  logic [ppp_pkg::CFG_W-1:0]      scale_r, scale_nxt;
  logic [ppp_pkg::DIV_W-1:0]      divisor_r, divisor_nxt;
  logic [ppp_pkg::DIV_W-1:0]      rem_r, rem_nxt;

  logic [ppp_pkg::QUO_W:0]        add_sum;
  logic [ppp_pkg::QUO_W-1:0]      mul_hi;
  logic [ppp_pkg::COORD_W-1:0]    mul_lo;
  logic [ppp_pkg::DIV_W:0]        shifted;
  logic [ppp_pkg::DIV_W+1:0]      diff;
  logic                           qbit;
  logic [ppp_pkg::DIV_W-1:0]      rem_step;

  always_comb begin
    add_sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);
    mul_hi   = add_sum[ppp_pkg::QUO_W:1];
    mul_lo   = {add_sum[0], lo_r[ppp_pkg::COORD_W-1:1]};
    shifted  = {rem_r, hi_r[ppp_pkg::QUO_W-1]};
    diff     = {1'b0, shifted} - {2'b00, divisor_r};
    qbit     = ~diff[ppp_pkg::DIV_W+1];
    rem_step = qbit ? diff[ppp_pkg::DIV_W-1:0] : shifted[ppp_pkg::DIV_W-1:0];
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    done_nxt    = 1'b0;
    hi_nxt      = hi_r;
    lo_nxt      = lo_r;
    mcand_nxt   = mcand_r;
    scale_nxt   = scale_r;
    divisor_nxt = divisor_r;
    rem_nxt     = rem_r;
    case (state_r)
      AX_IDLE: begin
        if (req.start) begin
          hi_nxt      = '0;
          lo_nxt      = req.mag;
          mcand_nxt   = {{(ppp_pkg::QUO_W - ppp_pkg::CFG_W){1'b0}}, req.fov};
          scale_nxt   = req.scale;
          divisor_nxt = req.divisor;
          cnt_nxt     = '0;
          state_nxt   = AX_MUL;
        end
      end
      AX_MUL: begin
        hi_nxt  = mul_hi;
        lo_nxt  = mul_lo;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ppp_pkg::CNT_W'(ppp_pkg::MUL_STEPS - 1)) begin
          mcand_nxt = {mul_hi[ppp_pkg::CFG_W-1:0], mul_lo};
          hi_nxt    = '0;
          lo_nxt    = scale_r;
        end
        if (cnt_r == ppp_pkg::CNT_W'(2 * ppp_pkg::MUL_STEPS - 1)) begin
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = AX_DIV;
        end
      end
      AX_DIV: begin
        hi_nxt  = {hi_r[ppp_pkg::QUO_W-2:0], qbit};
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ppp_pkg::CNT_W'(ppp_pkg::DIV_STEPS - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = AX_IDLE;
        end
      end
      default: begin
        state_nxt = AX_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AX_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;
    mcand_r   <= mcand_nxt;
    scale_r   <= scale_nxt;
    divisor_r <= divisor_nxt;
    rem_r     <= rem_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = hi_r;

endmodule
